// File: src/bal_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bal_pkg;

   localparam int LIST_DEPTH  = 64;
   localparam int ENTRY_WIDTH = 32;

   localparam int ADDR_W  = $clog2(LIST_DEPTH);
   localparam int CNT_W   = $clog2(LIST_DEPTH + 1);
   localparam int POS_W   = 8;
   localparam int VAL_W   = 32;
   localparam int CAP_W   = 7;
   localparam int OCNT_W  = 7;
   localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   localparam int REQ_W   = 48;
   localparam int RSP_W   = 48;

   typedef logic [1:0] op_type;
   localparam op_type OP_INSERT = 2'd0;
   localparam op_type OP_REMOVE = 2'd1;
   localparam op_type OP_READ   = 2'd2;
   localparam op_type OP_CLEAR  = 2'd3;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_BAD_INDEX = 2'd1;
   localparam status_type ST_FULL      = 2'd2;
   localparam status_type ST_EMPTY     = 2'd3;

   typedef struct packed {
      logic                   en;
      logic [ADDR_W-1:0]      addr;
      logic [ENTRY_WIDTH-1:0] data;
   } bal_wr_type;

   typedef struct packed {
      status_type        status;
      logic [VAL_W-1:0]  read_value;
      logic [CNT_W-1:0]  count;
   } bal_res_type;

endpackage
`default_nettype wire

// File: src/bal_store.sv
`timescale 1ns / 1ps
`default_nettype none
module bal_store (
   input  wire                              clock,
   input  wire  bal_pkg::bal_wr_type        wr,
   input  wire  [bal_pkg::ADDR_W-1:0]       rd_addr,
   output logic [bal_pkg::ENTRY_WIDTH-1:0]  rd_data
);
   import bal_pkg::*;

   logic [ENTRY_WIDTH-1:0] mem_ff [LIST_DEPTH];
   logic [ENTRY_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: src/bal_seq.sv
`timescale 1ns / 1ps
`default_nettype none
module bal_seq (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   input  wire  [1:0]                       op,
   input  wire  [bal_pkg::POS_W-1:0]        position,
   input  wire  [bal_pkg::VAL_W-1:0]        entry_value,
   input  wire  [bal_pkg::CNT_W-1:0]        cap_eff,
   output logic                             idle,
   output logic                             res_valid,
   input  wire                              res_ready,
   output bal_pkg::bal_res_type             res,
   output bal_pkg::bal_wr_type              wr,
   output logic [bal_pkg::ADDR_W-1:0]       rd_addr,
   input  wire  [bal_pkg::ENTRY_WIDTH-1:0]  rd_data
);
   import bal_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EVAL  = 3'd1;
   localparam logic [2:0] S_SHIFT = 3'd2;
   localparam logic [2:0] S_TAIL  = 3'd3;
   localparam logic [2:0] S_PUT   = 3'd4;
   localparam logic [2:0] S_READ  = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0]             state_ff,   state_in;
   op_type                 op_ff,      op_in;
   logic [POS_W-1:0]       pos_ff,     pos_in;
   logic [ENTRY_WIDTH-1:0] val_ff,     val_in;
   logic [CNT_W-1:0]       count_ff,   count_in;
   logic [ADDR_W-1:0]      ptr_ff,     ptr_in;
   logic [ADDR_W-1:0]      end_ff,     end_in;
   logic                   pend_ff,    pend_in;
   logic [ADDR_W-1:0]      waddr_ff,   waddr_in;
   status_type             status_ff,  status_in;

   logic [CMP_W-1:0]  pos_w;
   logic [CMP_W-1:0]  cnt_w;
   logic [CMP_W-1:0]  cap_w;
   logic [CNT_W-1:0]  cnt_dec;
   logic [ADDR_W-1:0] pos_a;
   logic              up;

   assign pos_w   = CMP_W'(pos_ff);
   assign cnt_w   = CMP_W'(count_ff);
   assign cap_w   = CMP_W'(cap_eff);
   assign cnt_dec = count_ff - CNT_W'(1);
   assign pos_a   = ADDR_W'(pos_ff);
   assign up      = (op_ff == OP_INSERT);

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      end_in    = end_ff;
      pend_in   = pend_ff;
      waddr_in  = waddr_ff;
      status_in = status_ff;
      wr.en     = 1'b0;
      wr.addr   = waddr_ff;
      wr.data   = rd_data;
      res_valid = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = op;
               pos_in   = position;
               val_in   = ENTRY_WIDTH'(entry_value);
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            status_in = ST_OK;
            pend_in   = 1'b0;
            state_in  = S_DONE;
            unique case (op_ff)
               OP_INSERT: begin
                  if (pos_w > cnt_w) begin
                     status_in = ST_BAD_INDEX;
                  end else if (cnt_w >= cap_w) begin
                     status_in = ST_FULL;
                  end else begin
                     count_in = count_ff + CNT_W'(1);
                     if (pos_w == cnt_w) begin
                        // append: no entries to move
                        wr.en   = 1'b1;
                        wr.addr = pos_a;
                        wr.data = val_ff;
                     end else begin
                        ptr_in   = ADDR_W'(cnt_dec);
                        end_in   = pos_a;
                        state_in = S_SHIFT;
                     end
                  end
               end
               OP_REMOVE: begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else if (pos_w >= cnt_w) begin
                     status_in = ST_BAD_INDEX;
                  end else begin
                     count_in = cnt_dec;
                     if (pos_w != CMP_W'(cnt_dec)) begin
                        ptr_in   = pos_a + ADDR_W'(1);
                        end_in   = ADDR_W'(cnt_dec);
                        state_in = S_SHIFT;
                     end
                  end
               end
               OP_READ: begin
                  if (pos_w >= cnt_w) begin
                     status_in = ST_BAD_INDEX;
                  end else begin
                     ptr_in   = pos_a;
                     state_in = S_READ;
                  end
               end
               OP_CLEAR: begin
                  count_in = '0;
               end
               default: ;
            endcase
         end
         S_SHIFT: begin
            // write the word fetched last cycle while fetching the next one
            wr.en    = pend_ff;
            pend_in  = 1'b1;
            waddr_in = up ? ptr_ff + ADDR_W'(1) : ptr_ff - ADDR_W'(1);
            if (ptr_ff == end_ff) begin
               state_in = S_TAIL;
            end else begin
               ptr_in = up ? ptr_ff - ADDR_W'(1) : ptr_ff + ADDR_W'(1);
            end
         end
         S_TAIL: begin
            wr.en    = 1'b1;
            pend_in  = 1'b0;
            state_in = up ? S_PUT : S_DONE;
         end
         S_PUT: begin
            wr.en    = 1'b1;
            wr.addr  = pos_a;
            wr.data  = val_ff;
            state_in = S_DONE;
         end
         S_READ: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      ptr_ff    <= ptr_in;
      end_ff    <= end_in;
      waddr_ff  <= waddr_in;
      status_ff <= status_in;
   end

   assign idle           = (state_ff == S_IDLE);
   assign rd_addr        = ptr_ff;
   assign res.status     = status_ff;
   assign res.count      = count_ff;
   assign res.read_value = (op_ff == OP_READ && status_ff == ST_OK) ? VAL_W'(rd_data) : '0;

endmodule
`default_nettype wire

// File: src/bounded_array_list_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// Ordered list of up to capacity_limit words with insert, remove, read and clear.
// req channel: one request per handshake; op, position and entry_value in req_tdata.
// rsp channel: exactly one response per request, in order: status, read_value,
//    entry_count, is_full, is_empty in rsp_tdata.
// csr channel: writes capacity_limit (0 acts as 1, above the depth acts as the depth);
//    always ready, write only while no request is outstanding.
// Sequencing: one request at a time, the sequencer holding req_tready low while busy.
//    Clear, append, removal of the last entry and refused requests go from S_EVAL
//    to S_DONE; a read passes S_READ for the memory fetch; an insert or remove
//    that moves entries walks them in S_SHIFT and finishes in S_TAIL, an insert
//    then in S_PUT. The single read and single write port of the list memory set
//    this: entries move one at a time. req_tready returns with rsp_tvalid.
// Reset: the count returns to zero and capacity_limit to 64; the list memory is
//    not cleared, as only written places are ever read.
// Stall: a response waits in the output register while rsp_tready is low; a
//    finished request waits in the sequencer until that register frees up.
module bounded_array_list_engine (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_tvalid,
   output logic                       req_tready,
   // [1:0] op, [9:2] position, [41:10] entry_value, [47:42] zero
   input  wire  [bal_pkg::REQ_W-1:0]  req_tdata,
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   // [1:0] status, [33:2] read_value, [40:34] entry_count, [41] is_full,
   // [42] is_empty, [47:43] zero
   output logic [bal_pkg::RSP_W-1:0]  rsp_tdata,
   input  wire                        csr_valid,
   output logic                       csr_ready,
   input  wire  [bal_pkg::CAP_W-1:0]  csr_data
);
   import bal_pkg::*;

   logic [CAP_W-1:0]       cap_ff,    cap_in;
   logic [CNT_W-1:0]       cap_eff;
   logic                   rvalid_ff, rvalid_in;
   status_type             rstat_ff,  rstat_in;
   logic [VAL_W-1:0]       rval_ff,   rval_in;
   logic [OCNT_W-1:0]      rcnt_ff,   rcnt_in;
   logic                   rfull_ff,  rfull_in;
   logic                   rempty_ff, rempty_in;

   logic                   idle;
   logic                   res_valid;
   logic                   res_ready;
   bal_res_type            res;
   bal_wr_type             wr;
   logic [ADDR_W-1:0]      rd_addr;
   logic [ENTRY_WIDTH-1:0] rd_data;
   logic                   accept;

   assign csr_ready = 1'b1;
   assign cap_in    = (csr_valid) ? csr_data : cap_ff;

   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CNT_W'(1);
      end else if (CMP_W'(cap_ff) > CMP_W'(LIST_DEPTH)) begin
         cap_eff = CNT_W'(LIST_DEPTH);
      end else begin
         cap_eff = CNT_W'(cap_ff);
      end
   end

   assign req_tready = idle;
   assign accept     = req_tvalid && idle;
   assign res_ready  = !rvalid_ff || rsp_tready;

   bal_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (accept),
      .op          (req_tdata[1:0]),
      .position    (req_tdata[9:2]),
      .entry_value (req_tdata[41:10]),
      .cap_eff     (cap_eff),
      .idle        (idle),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .wr          (wr),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data)
   );

   bal_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // load the output register when the sequencer finishes and the slot is free or its response is being taken
   always_comb begin
      rvalid_in = rvalid_ff;
      rstat_in  = rstat_ff;
      rval_in   = rval_ff;
      rcnt_in   = rcnt_ff;
      rfull_in  = rfull_ff;
      rempty_in = rempty_ff;
      if (rvalid_ff && rsp_tready) begin
         rvalid_in = 1'b0;
      end
      if (res_valid && res_ready) begin
         rvalid_in = 1'b1;
         rstat_in  = res.status;
         rval_in   = res.read_value;
         rcnt_in   = OCNT_W'(res.count);
         rfull_in  = (res.count >= cap_eff);
         rempty_in = (res.count == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff    <= CAP_W'(64);
         rvalid_ff <= 1'b0;
      end else begin
         cap_ff    <= cap_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rstat_ff  <= rstat_in;
      rval_ff   <= rval_in;
      rcnt_ff   <= rcnt_in;
      rfull_ff  <= rfull_in;
      rempty_ff <= rempty_in;
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {5'd0, rempty_ff, rfull_ff, rcnt_ff, rval_ff, rstat_ff};

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while sequencer busy");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (CMP_W'(rcnt_ff) <= CMP_W'(LIST_DEPTH)))
      else $error("entry count beyond list depth");

   a_full_empty_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rfull_ff && rempty_ff))
      else $error("list reported full and empty at once");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rstat_ff == ST_FULL |-> rfull_ff)
      else $error("full status without full flag");

   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rstat_ff != ST_OK |-> rval_ff == '0)
      else $error("read data on a refused request");

endmodule
`default_nettype wire

// File: dv/bounded_array_list_engine_tb.sv
`timescale 1ns / 1ps
module bounded_array_list_engine_tb;
   import bal_pkg::*;

   typedef struct packed {
      status_type  status;
      logic [31:0] read_value;
      logic [6:0]  entry_count;
      logic        is_full;
      logic        is_empty;
   } list_rsp_type;

   typedef struct {
      bit           is_cfg;
      logic [6:0]   cap;
      op_type       op;
      logic [7:0]   pos;
      logic [31:0]  val;
      bit           typed;
      list_rsp_type rsp;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CAP_W-1:0]     csr_data = '0;

   // predictor state
   logic [31:0]          list_model [0:LIST_DEPTH-1];
   logic [6:0]           count_model = '0;
   logic [6:0]           cap_reg = 7'd64;

   list_rsp_type         rsp_expected [$];
   stim_row_type         dir_rows [$];

   bit                   drv_typed = 1'b0;
   list_rsp_type         drv_rsp = '0;
   bit                   idle_on = 1'b0;
   int                   stall_left = 0;
   int                   errors = 0;
   int                   rsp_seen = 0;
   int                   op_hits [0:3] = '{0, 0, 0, 0};
   int                   status_hits [0:3] = '{0, 0, 0, 0};
   int                   cap_writes = 0;
   int                   peak_count = 0;
   list_rsp_type         got_rsp;
   list_rsp_type         want_rsp;
   list_rsp_type         pred_rsp;

   bounded_array_list_engine i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   initial begin
      #5ms;
      $display("bounded_array_list_engine regression: fail");
      $finish;
   end

   function automatic int eff_capacity();
      if (cap_reg == 7'd0) return 1;
      if (cap_reg > LIST_DEPTH) return LIST_DEPTH;
      return int'(cap_reg);
   endfunction

   // Apply one request to the list model and return the response it should give.
   function automatic list_rsp_type apply_list_op(op_type op, logic [7:0] pos,
                                                  logic [31:0] val);
      list_rsp_type r;
      int           cap;
      int           n;
      cap = eff_capacity();
      n = int'(count_model);
      r = '0;
      r.status = ST_OK;
      case (op)
         OP_INSERT: begin
            if (int'(pos) > n) begin
               r.status = ST_BAD_INDEX;
            end else if (n >= cap || n >= LIST_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               for (int i = n; i > int'(pos); i--) list_model[i] = list_model[i-1];
               list_model[ADDR_W'(pos)] = val;
               n++;
            end
         end
         OP_REMOVE: begin
            if (n == 0) begin
               r.status = ST_EMPTY;
            end else if (int'(pos) >= n) begin
               r.status = ST_BAD_INDEX;
            end else begin
               for (int i = int'(pos); i + 1 < n; i++) list_model[i] = list_model[i+1];
               n--;
            end
         end
         OP_READ: begin
            if (int'(pos) >= n || int'(pos) >= LIST_DEPTH) r.status = ST_BAD_INDEX;
            else r.read_value = list_model[ADDR_W'(pos)];
         end
         default: begin
            n = 0;
         end
      endcase
      count_model = n[6:0];
      r.entry_count = n[6:0];
      r.is_full = (n >= cap);
      r.is_empty = (n == 0);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                  input logic [31:0] want_v);
      $display("mismatch at response %0d: %s got %0h expected %0h",
               rsp_seen, what, got_v, want_v);
      errors++;
   endtask

   // Hold rsp_tready low after each response while the randomly drawn stall_left runs down.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready = 1'b0;
         stall_left--;
      end else begin
         rsp_tready = 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got_rsp.status      = rsp_tdata[1:0];
            got_rsp.read_value  = rsp_tdata[33:2];
            got_rsp.entry_count = rsp_tdata[40:34];
            got_rsp.is_full     = rsp_tdata[41];
            got_rsp.is_empty    = rsp_tdata[42];
            if (rsp_expected.size() == 0) begin
               report_mismatch("response with no request waiting, status",
                               32'(got_rsp.status), 32'd0);
            end else begin
               want_rsp = rsp_expected.pop_front();
               if (got_rsp.status !== want_rsp.status)
                  report_mismatch("status", 32'(got_rsp.status), 32'(want_rsp.status));
               if (got_rsp.read_value !== want_rsp.read_value)
                  report_mismatch("read_value", got_rsp.read_value, want_rsp.read_value);
               if (got_rsp.entry_count !== want_rsp.entry_count)
                  report_mismatch("entry_count", 32'(got_rsp.entry_count),
                                  32'(want_rsp.entry_count));
               if (got_rsp.is_full !== want_rsp.is_full)
                  report_mismatch("is_full", 32'(got_rsp.is_full), 32'(want_rsp.is_full));
               if (got_rsp.is_empty !== want_rsp.is_empty)
                  report_mismatch("is_empty", 32'(got_rsp.is_empty),
                                  32'(want_rsp.is_empty));
               status_hits[want_rsp.status]++;
            end
            rsp_seen++;
            stall_left = idle_on ? $urandom_range(0, 18) : 0;
         end
         if (req_tvalid && req_tready) begin
            pred_rsp = apply_list_op(op_type'(req_tdata[1:0]), req_tdata[9:2],
                                     req_tdata[41:10]);
            rsp_expected.push_back(drv_typed ? drv_rsp : pred_rsp);
            op_hits[req_tdata[1:0]]++;
            if (int'(count_model) > peak_count) peak_count = int'(count_model);
         end
         if (csr_valid && csr_ready) begin
            cap_reg = csr_data;
            cap_writes++;
         end
      end
   end

   task automatic send_req(input op_type op, input logic [7:0] pos, input logic [31:0] val,
                           input bit typed, input list_rsp_type rsp);
      int gap;
      gap = idle_on ? $urandom_range(0, 18) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {6'b0, val, pos, op};
      drv_typed = typed;
      drv_rsp = rsp;
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid and wait until every response has come back.
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (rsp_expected.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [6:0] cap);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data = cap;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic void row_cfg(logic [6:0] cap);
      stim_row_type r;
      r = '{default: '0};
      r.is_cfg = 1'b1;
      r.cap = cap;
      dir_rows.push_back(r);
   endfunction

   function automatic void row_req(op_type op, logic [7:0] pos, logic [31:0] val);
      stim_row_type r;
      r = '{default: '0};
      r.op = op;
      r.pos = pos;
      r.val = val;
      dir_rows.push_back(r);
   endfunction

   function automatic void row_chk(op_type op, logic [7:0] pos, logic [31:0] val,
                                   status_type st, logic [31:0] rd, logic [6:0] cnt,
                                   logic full, logic empty);
      stim_row_type r;
      r = '{default: '0};
      r.op = op;
      r.pos = pos;
      r.val = val;
      r.typed = 1'b1;
      r.rsp = '{st, rd, cnt, full, empty};
      dir_rows.push_back(r);
   endfunction

   initial begin
      logic [6:0]  cap_plan [0:8];
      op_type      op;
      logic [7:0]  pos;
      logic [31:0] val;
      int          r;
      int          limit;
      bit          filling;

      cap_plan = '{7'd64, 7'd1, 7'd127, 7'd8, 7'd0, 7'd40, 7'd64, 7'd3, 7'd64};
      cap_plan[8] = 7'($urandom_range(1, 127));

      // empty list, reset capacity
      row_chk(OP_READ,   8'd0,   32'h0,        ST_BAD_INDEX, 32'h0, 7'd0, 1'b0, 1'b1);
      row_chk(OP_REMOVE, 8'd0,   32'h0,        ST_EMPTY,     32'h0, 7'd0, 1'b0, 1'b1);
      row_chk(OP_REMOVE, 8'd255, 32'h0,        ST_EMPTY,     32'h0, 7'd0, 1'b0, 1'b1);
      row_chk(OP_INSERT, 8'd1,   32'h1,        ST_BAD_INDEX, 32'h0, 7'd0, 1'b0, 1'b1);
      row_chk(OP_INSERT, 8'd0,   32'hFFFFFFFF, ST_OK,        32'h0, 7'd1, 1'b0, 1'b0);
      row_chk(OP_INSERT, 8'd0,   32'h00000000, ST_OK,        32'h0, 7'd2, 1'b0, 1'b0);
      row_req(OP_INSERT, 8'd2,   32'hA5A55A5A);
      row_req(OP_INSERT, 8'd1,   32'h12345678);
      row_req(OP_READ,   8'd0,   32'hDEADBEEF);
      row_req(OP_READ,   8'd3,   32'h0);
      row_chk(OP_READ,   8'd4,   32'h0,        ST_BAD_INDEX, 32'h0, 7'd4, 1'b0, 1'b0);
      row_chk(OP_READ,   8'd255, 32'h0,        ST_BAD_INDEX, 32'h0, 7'd4, 1'b0, 1'b0);
      // removal at the count itself is out of range
      row_chk(OP_REMOVE, 8'd4,   32'h0,        ST_BAD_INDEX, 32'h0, 7'd4, 1'b0, 1'b0);
      row_req(OP_REMOVE, 8'd1,   32'h0);
      row_req(OP_REMOVE, 8'd2,   32'h0);
      row_req(OP_READ,   8'd1,   32'h0);
      row_chk(OP_CLEAR,  8'd0,   32'h0,        ST_OK,        32'h0, 7'd0, 1'b0, 1'b1);
      row_cfg(7'd1);
      row_chk(OP_INSERT, 8'd0,   32'h80000001, ST_OK,        32'h0, 7'd1, 1'b1, 1'b0);
      row_chk(OP_INSERT, 8'd0,   32'h7FFFFFFE, ST_FULL,      32'h0, 7'd1, 1'b1, 1'b0);
      // index is checked ahead of fullness
      row_chk(OP_INSERT, 8'd2,   32'h0,        ST_BAD_INDEX, 32'h0, 7'd1, 1'b1, 1'b0);
      row_cfg(7'd0);
      row_req(OP_READ,   8'd0,   32'h0);
      row_chk(OP_INSERT, 8'd1,   32'h0,        ST_FULL,      32'h0, 7'd1, 1'b1, 1'b0);
      row_cfg(7'd127);
      row_chk(OP_INSERT, 8'd1,   32'h55AA55AA, ST_OK,        32'h0, 7'd2, 1'b0, 1'b0);
      // capacity below the count: nothing dropped, list reads as full
      row_cfg(7'd1);
      row_req(OP_READ,   8'd1,   32'h0);
      row_chk(OP_INSERT, 8'd0,   32'h0,        ST_FULL,      32'h0, 7'd2, 1'b1, 1'b0);
      row_req(OP_REMOVE, 8'd0,   32'h0);
      row_chk(OP_CLEAR,  8'd0,   32'h0,        ST_OK,        32'h0, 7'd0, 1'b0, 1'b1);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      idle_on = 1'b1;
      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_cfg) begin
            drain();
            write_capacity(dir_rows[i].cap);
         end else begin
            send_req(dir_rows[i].op, dir_rows[i].pos, dir_rows[i].val,
                     dir_rows[i].typed, dir_rows[i].rsp);
         end
      end

      for (int p = 0; p < 9; p++) begin
         drain();
         write_capacity(cap_plan[p]);
         idle_on = (p % 3 != 0);
         filling = (p % 2 == 0);
         for (int k = 0; k < 100; k++) begin
            r = $urandom_range(0, 99);
            if (r < 1) op = OP_CLEAR;
            else if (r < (filling ? 61 : 31)) op = OP_INSERT;
            else if (r < (filling ? 76 : 71)) op = OP_REMOVE;
            else op = OP_READ;
            // mostly in-range positions, some just past the end, some anywhere
            limit = (op == OP_INSERT) ? int'(count_model)
                  : ((count_model == 0) ? 0 : int'(count_model) - 1);
            r = $urandom_range(0, 9);
            if (r < 8) pos = 8'($urandom_range(0, limit));
            else if (r == 8) pos = 8'(count_model) + 8'($urandom_range(0, 1));
            else pos = 8'($urandom_range(0, 255));
            r = $urandom_range(0, 15);
            if (r == 0) val = 32'h0;
            else if (r == 1) val = 32'hFFFFFFFF;
            else val = $urandom;
            send_req(op, pos, val, 1'b0, '0);
         end
      end

      @(negedge clock);
      req_tvalid = 1'b0;
      while (rsp_expected.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      while (rsp_expected.size() != 0) begin
         want_rsp = rsp_expected.pop_front();
         report_mismatch("response never arrived, expected status", 32'd0,
                         32'(want_rsp.status));
      end

      $display("ran %0d requests (insert %0d, remove %0d, read %0d, clear %0d), %0d responses",
               op_hits[0] + op_hits[1] + op_hits[2] + op_hits[3],
               op_hits[0], op_hits[1], op_hits[2], op_hits[3], rsp_seen);
      $display("statuses ok/bad index/full/empty %0d/%0d/%0d/%0d, %0d capacity writes, peak %0d",
               status_hits[0], status_hits[1], status_hits[2], status_hits[3],
               cap_writes, peak_count);
      if (errors == 0) begin
         $display("bounded_array_list_engine regression: pass");
      end else begin
         $display("bounded_array_list_engine regression: fail");
      end
      $finish;
   end

endmodule
